### hw/rtl/hbd_pkg.sv
`timescale 1ns / 1ps

package hbd_pkg;

  // Field widths of one input beat and one result beat
  localparam int KIND_W     = 2;
  localparam int NODE_IDX_W = 9;
  localparam int SYMBOL_W   = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int LIMIT_W     = 32;

  // Parameter defaults
  localparam int NODE_COUNT_DEF  = 512;
  localparam int SYMBOL_BITS_DEF = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 2'd0,
    KIND_BIT     = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROOT_INDEX   = 1'b0,
    CFG_SYMBOL_LIMIT = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [NODE_IDX_W-1:0] node_index;
    logic [NODE_IDX_W-1:0] left_child;
    logic                  left_present;
    logic [NODE_IDX_W-1:0] right_child;
    logic                  right_present;
    logic [SYMBOL_W-1:0]   node_symbol;
    logic                  bit_value;
  } in_item_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                limit_reached;
  } out_item_t;

endpackage

### hw/rtl/huffman_bit_decoder_core.sv
`timescale 1ns / 1ps

// Huffman tree-walk decoder over a node table held in an on-chip RAM.
// Input channel (in_valid_i / in_stall_o, payload in_data_i): a beat either
// writes one node, restarts the walk at the root, or carries one code bit.
// Output channel (out_valid_o / out_stall_i, payload out_data_o): one beat
// per decoded symbol, with limit_reached set on the symbol that reaches
// symbol_limit. Config port (cfg_we_i, cfg_index_i, cfg_data_i) sets
// root_index and symbol_limit; write it only while the decoder is idle.
// Throughput: one input beat per cycle, sustained while in_stall_o is low.
// The registered entry of the current node selects the child address, so
// each bit needs one read of the node table port; the root entry comes from
// a second read port. out_valid_o rises at the edge after the one that
// accepts the bit that completes a symbol.
// Stall: a two-beat output buffer absorbs the receiver stalling; in_stall_o
// rises once the buffer has no room left for a beat still in the walk.
// Reset clears the walk to node 0, the symbol count, the halt flag and both
// config registers; the node table is not cleared and must be written
// before its entries are walked.
module huffman_bit_decoder_core #(
  parameter int NODE_COUNT  = hbd_pkg::NODE_COUNT_DEF,
  parameter int SYMBOL_BITS = hbd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hbd_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hbd_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [hbd_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [hbd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import hbd_pkg::*;

  localparam int IW      = $clog2(NODE_COUNT);
  localparam int IDX_MAX = (1 << NODE_IDX_W) - 1;

  // Reduce a node index field modulo the table size
  function automatic logic [NODE_IDX_W-1:0] slot(input logic [NODE_IDX_W-1:0] v);
    logic [NODE_IDX_W-1:0] r;
    r = v;
    for (int k = 7; k >= 0; k--) begin
      if (((NODE_COUNT << k) <= IDX_MAX) && (int'(r) >= (NODE_COUNT << k))) begin
        r = r - NODE_IDX_W'(NODE_COUNT << k);
      end
    end
    return r;
  endfunction

  logic [IW-1:0]      root_idx_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [IW-1:0]      root_wr_idx;
  logic               root_wr;
  logic               fire;
  logic               emit;
  out_item_t          emit_item;
  logic               busy;
  logic               full;
  logic [IW-1:0]      node_idx;
  logic [IW-1:0]      left_idx;
  logic [IW-1:0]      right_idx;

  assign fire        = in_valid_i && !in_stall_o;
  assign in_stall_o  = full;
  assign root_wr     = cfg_we_i && (cfg_index_i == CFG_ROOT_INDEX);
  assign root_wr_idx = IW'(slot(cfg_data_i[NODE_IDX_W-1:0]));
  assign node_idx    = IW'(slot(in_data_i.node_index));
  assign left_idx    = IW'(slot(in_data_i.left_child));
  assign right_idx   = IW'(slot(in_data_i.right_child));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_idx_q <= '0;
      limit_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROOT_INDEX:   root_idx_q <= root_wr_idx;
        CFG_SYMBOL_LIMIT: limit_q    <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  hbd_walk #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (in_data_i),
    .node_idx_i    (node_idx),
    .left_idx_i    (left_idx),
    .right_idx_i   (right_idx),
    .root_idx_i    (root_idx_q),
    .root_wr_i     (root_wr),
    .root_wr_idx_i (root_wr_idx),
    .limit_i       (limit_q),
    .emit_o        (emit),
    .emit_item_o   (emit_item),
    .busy_o        (busy)
  );

  hbd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_item_i (emit_item),
    .busy_i      (busy),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_data_o)
  );

endmodule

### hw/rtl/hbd_ram.sv
`timescale 1ns / 1ps

module hbd_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Reads return the data from before a write to the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

### hw/rtl/hbd_out_buf.sv
`timescale 1ns / 1ps

module hbd_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hbd_pkg::out_item_t push_item_i,
  input  logic               busy_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hbd_pkg::out_item_t out_item_o
);

  import hbd_pkg::*;

  logic [1:0] occ_q, occ_d;
  logic [1:0] left;
  logic [2:0] claim;
  logic       pop;
  out_item_t  s0_q, s0_d, s1_q, s1_d;

  assign pop         = (occ_q != 2'd0) && !out_stall_i;
  assign left        = occ_q - {1'b0, pop};
  // Reserve a slot for the beat still in flight in the walk
  assign claim       = {1'b0, left} + {2'b00, busy_i};
  assign full_o      = claim >= 3'd2;
  assign out_valid_o = occ_q != 2'd0;
  assign out_item_o  = s0_q;

  always_comb begin
    s0_d  = s0_q;
    s1_d  = s1_q;
    occ_d = left + {1'b0, push_i};
    if (pop) begin
      s0_d = s1_q;
    end
    if (push_i) begin
      if (left == 2'd0) begin
        s0_d = push_item_i;
      end else begin
        s1_d = push_item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 2'd0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && (left == 2'd2)))
    else $error("result pushed into a full output buffer");

  a_stall_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && (out_item_o == $past(out_item_o)))
    else $error("stalled result beat changed");
`endif

endmodule

### hw/rtl/hbd_walk.sv
`timescale 1ns / 1ps

module hbd_walk #(
  parameter int NODE_COUNT  = hbd_pkg::NODE_COUNT_DEF,
  parameter int SYMBOL_BITS = hbd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  hbd_pkg::in_item_t             item_i,
  input  logic [$clog2(NODE_COUNT)-1:0] node_idx_i,
  input  logic [$clog2(NODE_COUNT)-1:0] left_idx_i,
  input  logic [$clog2(NODE_COUNT)-1:0] right_idx_i,
  input  logic [$clog2(NODE_COUNT)-1:0] root_idx_i,
  input  logic                          root_wr_i,
  input  logic [$clog2(NODE_COUNT)-1:0] root_wr_idx_i,
  input  logic [hbd_pkg::LIMIT_W-1:0]   limit_i,
  output logic                          emit_o,
  output hbd_pkg::out_item_t            emit_item_o,
  output logic                          busy_o
);

  import hbd_pkg::*;

  localparam int IW         = $clog2(NODE_COUNT);
  localparam int SYM_W      = (SYMBOL_BITS < SYMBOL_W) ? SYMBOL_BITS : SYMBOL_W;
  localparam int E_RIGHT_LO = SYM_W;
  localparam int E_LEFT_LO  = SYM_W + IW;
  localparam int E_RP       = SYM_W + 2 * IW;
  localparam int E_LP       = E_RP + 1;
  localparam int ENT_W      = E_LP + 1;

  // Walk state; cur_ent_q mirrors the table entry of cur_idx_q unless a step is pending
  logic [IW-1:0]      cur_idx_q, cur_idx_d;
  logic [ENT_W-1:0]   cur_ent_q, cur_ent_d;
  logic               pend_q, pend_d;
  logic               self_q, self_d;
  logic [SYM_W-1:0]   self_sym_q, self_sym_d;
  logic [LIMIT_W-1:0] count_q, count_d;
  logic               halted_q, halted_d;
  logic               fwd_vld_q;
  logic [ENT_W-1:0]   fwd_ent_q;

  logic               we;
  logic [ENT_W-1:0]   wdata;
  logic [IW-1:0]      raddr_b;
  logic [ENT_W-1:0]   rdata_a, rdata_b;

  logic [ENT_W-1:0]   root_ent;
  logic               step_leaf;
  logic               b_emit;
  logic [SYM_W-1:0]   b_sym;
  logic [LIMIT_W-1:0] inc;
  logic               inc_ge;
  logic               cnt_ge;
  logic               halted_eff;
  logic               at_lim_eff;
  logic [LIMIT_W-1:0] count_eff;
  logic [IW-1:0]      cur_idx_eff;
  logic [ENT_W-1:0]   cur_ent_eff;
  logic               cur_leaf;
  logic [IW-1:0]      child;
  logic               child_ok;

  assign wdata   = {item_i.left_present, item_i.right_present, left_idx_i, right_idx_i,
                    item_i.node_symbol[SYM_W-1:0]};
  assign raddr_b = root_wr_i ? root_wr_idx_i : root_idx_i;

  hbd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (node_idx_i),
    .wdata_i   (wdata),
    .raddr_a_i (child),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // Finish the older beat first, then work the new beat on the state it leaves
  assign root_ent    = fwd_vld_q ? fwd_ent_q : rdata_b;
  assign step_leaf   = !rdata_a[E_LP] && !rdata_a[E_RP];
  assign b_emit      = self_q || (pend_q && step_leaf);
  assign b_sym       = self_q ? self_sym_q : rdata_a[SYM_W-1:0];
  assign inc         = count_q + LIMIT_W'(1);
  assign inc_ge      = inc >= limit_i;
  assign cnt_ge      = count_q >= limit_i;
  assign halted_eff  = halted_q || (b_emit && inc_ge);
  assign at_lim_eff  = b_emit ? inc_ge : cnt_ge;
  assign count_eff   = b_emit ? inc : count_q;
  assign cur_idx_eff = b_emit ? root_idx_i : cur_idx_q;
  assign cur_ent_eff = b_emit ? root_ent : (pend_q ? rdata_a : cur_ent_q);
  assign cur_leaf    = !cur_ent_eff[E_LP] && !cur_ent_eff[E_RP];
  assign child       = item_i.bit_value ? cur_ent_eff[E_RIGHT_LO +: IW]
                                        : cur_ent_eff[E_LEFT_LO +: IW];
  assign child_ok    = item_i.bit_value ? cur_ent_eff[E_RP] : cur_ent_eff[E_LP];

  assign emit_o                    = b_emit;
  assign emit_item_o.symbol        = SYMBOL_W'(b_sym);
  assign emit_item_o.limit_reached = inc_ge;
  assign busy_o                    = pend_q || self_q;

  always_comb begin
    cur_idx_d  = cur_idx_eff;
    cur_ent_d  = cur_ent_eff;
    pend_d     = 1'b0;
    self_d     = 1'b0;
    self_sym_d = self_sym_q;
    count_d    = count_eff;
    halted_d   = halted_eff;
    we         = 1'b0;
    if (fire_i) begin
      case (item_i.kind)
        KIND_WRITE: begin
          we = 1'b1;
          if (node_idx_i == cur_idx_eff) begin
            cur_ent_d = wdata;
          end
        end
        KIND_RESTART: begin
          cur_idx_d = root_idx_i;
          cur_ent_d = root_ent;
          count_d   = '0;
          halted_d  = 1'b0;
        end
        KIND_BIT: begin
          if (!halted_eff) begin
            if (at_lim_eff) begin
              halted_d = 1'b1;
            end else if (cur_leaf) begin
              // One-symbol tree: emit the current node itself
              self_d     = 1'b1;
              self_sym_d = cur_ent_eff[SYM_W-1:0];
            end else if (!child_ok) begin
              halted_d = 1'b1;
            end else begin
              cur_idx_d = child;
              pend_d    = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_idx_q <= '0;
      pend_q    <= 1'b0;
      self_q    <= 1'b0;
      count_q   <= '0;
      halted_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      cur_idx_q <= cur_idx_d;
      pend_q    <= pend_d;
      self_q    <= self_d;
      count_q   <= count_d;
      halted_q  <= halted_d;
      fwd_vld_q <= we && (node_idx_i == raddr_b);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_ent_q  <= cur_ent_d;
    self_sym_q <= self_sym_d;
    fwd_ent_q  <= wdata;
  end

`ifndef NO_ASSERTIONS
  a_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && self_q))
    else $error("step and self emit pending together");

  a_halted_bit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.kind == KIND_BIT) && halted_eff |=> !pend_q && !self_q)
    else $error("bit launched work while halted");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.kind == KIND_RESTART) |=> (count_q == '0) && !halted_q)
    else $error("restart did not clear count and halt");

  a_limit_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_emit && inc_ge && !(fire_i && (item_i.kind == KIND_RESTART)) |=> halted_q)
    else $error("symbol at limit did not halt the walk");
`endif

endmodule
